// ===== hw/rtl/rts_pkg.sv =====
// ----------------------------------------------------------------------------
// rts_pkg
// Shared types and constants for the radix trie sparse map.
// ----------------------------------------------------------------------------
package rts_pkg;

  localparam int unsigned PoolNodes = 256;
  localparam int unsigned DigitBits = 4;
  localparam int unsigned Levels    = 8;
  localparam int unsigned ValueBits = 32;
  localparam int unsigned KeyBits   = 32;

  localparam int unsigned Fanout  = 1 << DigitBits;
  localparam int unsigned NodeW   = $clog2(PoolNodes);
  localparam int unsigned LvlW    = $clog2(Levels);
  localparam int unsigned DepthW  = $clog2(Levels + 1);
  localparam int unsigned SlotAw  = NodeW + DigitBits;
  localparam int unsigned SlotW   = ValueBits + 1;
  localparam int unsigned CntW    = $clog2(PoolNodes + 1);
  localparam int unsigned FillW   = $clog2(Fanout + 1);

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_LOOKUP = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_TOGGLE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STAT_DONE     = 2'd0,
    STAT_OCCUPIED = 2'd1,
    STAT_MISSING  = 2'd2,
    STAT_NO_POOL  = 2'd3
  } status_e;

endpackage

// ===== hw/rtl/rts_ram.sv =====
// ----------------------------------------------------------------------------
// rts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rts_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hw/rtl/radix_trie_sparse_map.sv =====
// ----------------------------------------------------------------------------
// radix_trie_sparse_map
// 16-way, eight-level radix trie map from 32-bit keys to 32-bit values.
// ----------------------------------------------------------------------------
// One request at a time. busy is high from the accepting edge until the cycle
// after done; done pulses for one cycle with status, found and value_out and
// cannot be held off. Every memory read is registered, so the walk spends a
// read state and a check state on each level. Remove, and toggle on a present
// key, then walk back up, checking each node's fill count on the way.
// Insert takes a free-list pop, a clear of all 16 slots and a link for each
// new node, and writes the leaf last.
// No clearing pass after reset: nodes are cleared as they are allocated.
// ----------------------------------------------------------------------------
module radix_trie_sparse_map (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode_i,
  input  logic [31:0] key_i,
  input  logic [31:0] value_in_i,
  output logic        done,
  output logic [1:0]  status_o,
  output logic        found_o,
  output logic [31:0] value_out_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_WRD, S_WCHK, S_DECIDE, S_URD, S_UCHK, S_INCRD, S_INCWR,
    S_POP, S_GET, S_CLR, S_LINK, S_LEAF, S_DONE
  } state_e;

  state_e state_q;

  rts_pkg::mode_e                    mode_q;
  logic [rts_pkg::KeyBits-1:0]       key_q;
  logic [rts_pkg::ValueBits-1:0]     val_q;
  logic [rts_pkg::NodeW-1:0]         path_q [rts_pkg::Levels];
  logic [rts_pkg::NodeW-1:0]         node_q;
  logic [rts_pkg::LvlW-1:0]          lvl_q;
  logic [rts_pkg::DepthW-1:0]        depth_q;
  logic                              leafv_q;
  logic [rts_pkg::ValueBits-1:0]     leafd_q;
  logic                              root_present_q;
  logic [rts_pkg::NodeW-1:0]         root_node_q;
  logic [rts_pkg::CntW-1:0]          cnt_q;
  logic [rts_pkg::CntW-1:0]          wmark_q;
  logic [rts_pkg::CntW-1:0]          pop_idx_q;
  logic                              pop_written_q;
  logic [rts_pkg::DigitBits-1:0]     clr_q;

  // memory ports
  logic                              slot_we;
  logic [rts_pkg::SlotAw-1:0]        slot_waddr, slot_raddr;
  logic [rts_pkg::SlotW-1:0]         slot_wdata, slot_rdata;
  logic                              fill_we;
  logic [rts_pkg::NodeW-1:0]         fill_waddr, fill_raddr;
  logic [rts_pkg::FillW-1:0]         fill_wdata, fill_rdata;
  logic                              fl_we;
  logic [rts_pkg::NodeW-1:0]         fl_waddr, fl_raddr;
  logic [rts_pkg::NodeW-1:0]         fl_wdata, fl_rdata;

  function automatic logic [rts_pkg::DigitBits-1:0] digit_at(
    logic [rts_pkg::KeyBits-1:0] key,
    logic [rts_pkg::LvlW-1:0]    lvl
  );
    logic [rts_pkg::LvlW-1:0] inv;
    inv = rts_pkg::LvlW'(rts_pkg::Levels - 1) - lvl;
    return key[inv * rts_pkg::DigitBits +: rts_pkg::DigitBits];
  endfunction

  localparam logic [rts_pkg::LvlW-1:0] LastLvl = rts_pkg::LvlW'(rts_pkg::Levels - 1);

  logic [rts_pkg::LvlW-1:0]       lvl_m1;
  logic [rts_pkg::LvlW-1:0]       dep_m1;
  logic [rts_pkg::FillW-1:0]      fill_dec;
  logic [rts_pkg::NodeW-1:0]      pop_node;
  logic [rts_pkg::DepthW-1:0]     need;
  logic                           leaf_hit;

  assign lvl_m1   = lvl_q - 1'b1;
  assign dep_m1   = rts_pkg::LvlW'(depth_q - 1'b1);
  assign fill_dec = (fill_rdata != '0) ? fill_rdata - 1'b1 : '0;
  assign pop_node = pop_written_q ? fl_rdata : pop_idx_q[rts_pkg::NodeW-1:0];
  assign need     = rts_pkg::DepthW'(rts_pkg::Levels) - depth_q;
  assign leaf_hit = (depth_q == rts_pkg::DepthW'(rts_pkg::Levels)) && leafv_q;

  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = '0;
    slot_wdata = '0;
    slot_raddr = {node_q, digit_at(key_q, lvl_q)};
    fill_we    = 1'b0;
    fill_waddr = '0;
    fill_wdata = '0;
    fill_raddr = path_q[lvl_q];
    fl_we      = 1'b0;
    fl_waddr   = cnt_q[rts_pkg::NodeW-1:0];
    fl_wdata   = path_q[lvl_q];
    fl_raddr   = cnt_q[rts_pkg::NodeW-1:0] - 1'b1;
    case (state_q)
      S_DECIDE: begin
        if ((mode_q == rts_pkg::MODE_REMOVE || mode_q == rts_pkg::MODE_TOGGLE) &&
            leaf_hit) begin
          slot_we    = 1'b1;
          slot_waddr = {path_q[LastLvl], digit_at(key_q, LastLvl)};
        end
      end
      S_INCRD: fill_raddr = path_q[dep_m1];
      S_INCWR: begin
        fill_we    = 1'b1;
        fill_waddr = path_q[dep_m1];
        fill_wdata = fill_rdata + 1'b1;
      end
      S_UCHK: begin
        fill_we    = 1'b1;
        fill_waddr = path_q[lvl_q];
        fill_wdata = fill_dec;
        if (fill_dec == '0) begin
          fl_we = (cnt_q < rts_pkg::CntW'(rts_pkg::PoolNodes));
          if (lvl_q != '0) begin
            slot_we    = 1'b1;
            slot_waddr = {path_q[lvl_m1], digit_at(key_q, lvl_m1)};
          end
        end
      end
      S_CLR: begin
        slot_we    = 1'b1;
        slot_waddr = {node_q, clr_q};
        if (clr_q == '1) begin
          fill_we    = 1'b1;
          fill_waddr = node_q;
          fill_wdata = rts_pkg::FillW'(1);
        end
      end
      S_LINK: begin
        if (lvl_q != '0) begin
          slot_we    = 1'b1;
          slot_waddr = {path_q[lvl_m1], digit_at(key_q, lvl_m1)};
          slot_wdata = {1'b1, rts_pkg::ValueBits'(node_q)};
        end
      end
      S_LEAF: begin
        slot_we    = 1'b1;
        slot_waddr = {path_q[LastLvl], digit_at(key_q, LastLvl)};
        slot_wdata = {1'b1, val_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      root_present_q <= 1'b0;
      root_node_q    <= '0;
      cnt_q          <= rts_pkg::CntW'(rts_pkg::PoolNodes);
      wmark_q        <= rts_pkg::CntW'(rts_pkg::PoolNodes);
      status_o       <= rts_pkg::STAT_DONE;
      found_o        <= 1'b0;
      value_out_o    <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start) begin
            mode_q      <= rts_pkg::mode_e'(mode_i);
            key_q       <= key_i;
            val_q       <= value_in_i;
            node_q      <= root_node_q;
            lvl_q       <= '0;
            depth_q     <= '0;
            leafv_q     <= 1'b0;
            leafd_q     <= '0;
            status_o    <= rts_pkg::STAT_DONE;
            found_o     <= 1'b0;
            value_out_o <= '0;
            state_q     <= root_present_q ? S_WRD : S_DECIDE;
          end
        end
        S_WRD: begin
          path_q[lvl_q] <= node_q;
          state_q       <= S_WCHK;
        end
        S_WCHK: begin
          if (lvl_q == LastLvl) begin
            depth_q <= rts_pkg::DepthW'(rts_pkg::Levels);
            leafv_q <= slot_rdata[rts_pkg::SlotW-1];
            leafd_q <= slot_rdata[rts_pkg::ValueBits-1:0];
            state_q <= S_DECIDE;
          end else if (!slot_rdata[rts_pkg::SlotW-1]) begin
            depth_q <= rts_pkg::DepthW'(lvl_q) + 1'b1;
            state_q <= S_DECIDE;
          end else begin
            node_q  <= slot_rdata[rts_pkg::NodeW-1:0];
            lvl_q   <= lvl_q + 1'b1;
            state_q <= S_WRD;
          end
        end
        S_DECIDE: begin
          if (mode_q == rts_pkg::MODE_LOOKUP) begin
            status_o    <= leaf_hit ? rts_pkg::STAT_DONE : rts_pkg::STAT_MISSING;
            found_o     <= leaf_hit;
            value_out_o <= leaf_hit ? leafd_q : '0;
            state_q     <= S_DONE;
          end else if (mode_q != rts_pkg::MODE_INSERT && leaf_hit) begin
            found_o     <= 1'b1;
            value_out_o <= leafd_q;
            lvl_q       <= LastLvl;
            state_q     <= S_URD;
          end else if (mode_q == rts_pkg::MODE_REMOVE) begin
            status_o <= rts_pkg::STAT_MISSING;
            state_q  <= S_DONE;
          end else if (leaf_hit) begin
            status_o <= rts_pkg::STAT_OCCUPIED;
            state_q  <= S_DONE;
          end else if (rts_pkg::CntW'(need) > cnt_q) begin
            status_o <= rts_pkg::STAT_NO_POOL;
            state_q  <= S_DONE;
          end else begin
            lvl_q   <= rts_pkg::LvlW'(depth_q);
            state_q <= (depth_q != '0) ? S_INCRD : S_POP;
          end
        end
        S_URD: state_q <= S_UCHK;
        S_UCHK: begin
          if (fill_dec != '0) begin
            state_q <= S_DONE;
          end else begin
            if (cnt_q < rts_pkg::CntW'(rts_pkg::PoolNodes)) begin
              cnt_q <= cnt_q + 1'b1;
            end
            if (lvl_q == '0) begin
              root_present_q <= 1'b0;
              root_node_q    <= '0;
              state_q        <= S_DONE;
            end else begin
              lvl_q   <= lvl_m1;
              state_q <= S_URD;
            end
          end
        end
        S_INCRD: state_q <= S_INCWR;
        S_INCWR: begin
          state_q <= (depth_q == rts_pkg::DepthW'(rts_pkg::Levels)) ? S_LEAF : S_POP;
        end
        S_POP: begin
          cnt_q         <= cnt_q - 1'b1;
          pop_idx_q     <= cnt_q - 1'b1;
          pop_written_q <= (wmark_q <= cnt_q - 1'b1);
          if (cnt_q - 1'b1 < wmark_q) begin
            wmark_q <= cnt_q - 1'b1;
          end
          state_q <= S_GET;
        end
        S_GET: begin
          node_q  <= pop_node;
          clr_q   <= '0;
          state_q <= S_CLR;
        end
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == '1) begin
            state_q <= S_LINK;
          end
        end
        S_LINK: begin
          path_q[lvl_q] <= node_q;
          if (lvl_q == '0) begin
            root_present_q <= 1'b1;
            root_node_q    <= node_q;
          end
          if (lvl_q == LastLvl) begin
            state_q <= S_LEAF;
          end else begin
            lvl_q   <= lvl_q + 1'b1;
            state_q <= S_POP;
          end
        end
        S_LEAF: state_q <= S_DONE;
        S_DONE: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy = (state_q != S_IDLE);
  assign done = (state_q == S_DONE);

  rts_ram #(.Width(rts_pkg::SlotW), .Depth(rts_pkg::PoolNodes * rts_pkg::Fanout)) u_slot (
    .clk_i  (clk_i),
    .we_i   (slot_we),
    .waddr_i(slot_waddr),
    .wdata_i(slot_wdata),
    .raddr_i(slot_raddr),
    .rdata_o(slot_rdata)
  );

  rts_ram #(.Width(rts_pkg::FillW), .Depth(rts_pkg::PoolNodes)) u_fill (
    .clk_i  (clk_i),
    .we_i   (fill_we),
    .waddr_i(fill_waddr),
    .wdata_i(fill_wdata),
    .raddr_i(fill_raddr),
    .rdata_o(fill_rdata)
  );

  rts_ram #(.Width(rts_pkg::NodeW), .Depth(rts_pkg::PoolNodes)) u_free (
    .clk_i  (clk_i),
    .we_i   (fl_we),
    .waddr_i(fl_waddr),
    .wdata_i(fl_wdata),
    .raddr_i(fl_raddr),
    .rdata_o(fl_rdata)
  );

  a_done_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> busy) else $error("done outside a transfer");

  a_done_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> !busy) else $error("busy held after done");

  a_found_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done && found_o) |-> (status_o == rts_pkg::STAT_DONE))
    else $error("found with error status");

  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q <= rts_pkg::CntW'(rts_pkg::PoolNodes)) && (wmark_q <= cnt_q))
    else $error("free count out of range");

endmodule
